FILE: hw/rtl/ppe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppe_pkg
// Types and constants shared by the particle pool engine.
// ----------------------------------------------------------------------------
package ppe_pkg;

  localparam logic ACT_SPAWN = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  localparam logic [1:0] KIND_SPAWN = 2'd0;
  localparam logic [1:0] KIND_LIVE  = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;

  localparam logic [15:0] ONE_Q14   = 16'd16384;
  localparam logic [14:0] HALF_Q14  = 15'd8192;

  // reciprocal multipliers: ceil(2^k / d)
  localparam logic [25:0] RCP_TEN     = 26'd13421773; // k = 27
  localparam logic [25:0] RCP_FIVE    = 26'd13108;    // k = 16
  localparam logic [25:0] RCP_HUNDRED = 26'd2684355;  // k = 28

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b000000000001,
    ST_SEARCH = 12'b000000000010,
    ST_SP_VX  = 12'b000000000100,
    ST_SP_VY  = 12'b000000001000,
    ST_SP_JIT = 12'b000000010000,
    ST_SP_SH  = 12'b000000100000,
    ST_SP_WR  = 12'b000001000000,
    ST_T_RD   = 12'b000010000000,
    ST_T_MX   = 12'b000100000000,
    ST_T_MY   = 12'b001000000000,
    ST_T_WR   = 12'b010000000000,
    ST_T_END  = 12'b100000000000
  } state_t;

endpackage

FILE: hw/rtl/particle_pool_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_pool_engine_unit
// Particle pool with free slot search, spawn and per-tick aging.
// ----------------------------------------------------------------------------
// The block keeps POOL_SIZE particles in on-chip memories and works on one
// input beat at a time; in_ready is high only while idle. A spawn beat walks
// the live flags one slot per cycle from the last chosen slot, then uses one
// shared 26x26 multiplier (velocity / 10, jitter / 5, brightness / 100 by
// reciprocal) and a write state that stores the slot and presents its
// result. A tick beat visits every slot: a memory read and an aging step for
// a slot that is or becomes dead, and for a survivor also x and y motion on
// the shared multiplier and a write, then a closing state after the last
// slot. Each tick result is held back one survivor so that last marks the
// final one; a tick with no survivor gives one kind 2 beat.
// Output beats stall the sequencer only while the output register is full.
// ----------------------------------------------------------------------------
module particle_pool_engine_unit
  import ppe_pkg::*;
#(
  parameter int POOL_SIZE = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic [15:0]        tick_time,
  input  logic signed [23:0] obj_pos_x,
  input  logic signed [23:0] obj_pos_y,
  input  logic signed [23:0] obj_vel_x,
  input  logic signed [23:0] obj_vel_y,
  input  logic signed [23:0] offset_x,
  input  logic signed [23:0] offset_y,
  input  logic [6:0]         jitter_raw,
  input  logic [6:0]         bright_raw,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic [5:0]         slot,
  output logic signed [23:0] part_x,
  output logic signed [23:0] part_y,
  output logic [14:0]        shade,
  output logic [14:0]        opacity,
  output logic               last
);

  localparam int IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CW = $clog2(POOL_SIZE + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(POOL_SIZE - 1);
  localparam logic [CW-1:0] LAST_CNT = CW'(POOL_SIZE - 1);

  state_t state;

  // pool memories
  logic [15:0] life_mem  [POOL_SIZE];
  logic [23:0] posx_mem  [POOL_SIZE];
  logic [23:0] posy_mem  [POOL_SIZE];
  logic [23:0] velx_mem  [POOL_SIZE];
  logic [23:0] vely_mem  [POOL_SIZE];
  logic [14:0] shade_mem [POOL_SIZE];
  logic [14:0] op_mem    [POOL_SIZE];
  logic [POOL_SIZE-1:0] live;

  // captured input beat
  logic signed [23:0] ipx, ipy, ivx, ivy, iox, ioy;
  logic [6:0]  ijit, ibr;
  logic [15:0] dt, dlife, dalpha;

  logic [IW-1:0] idx, search_start;
  logic [CW-1:0] cnt;

  // spawn intermediates
  logic [23:0] vx_q, vy_q;
  logic signed [11:0] jit_q;

  // tick read data
  logic [15:0] rd_life;
  logic        rd_live;
  logic [23:0] rd_px, rd_py, rd_vx, rd_vy;
  logic [14:0] rd_sh, rd_op;
  logic [23:0] nx;

  // held-back tick result
  logic        pend;
  logic [IW-1:0] pend_slot;
  logic [23:0] pend_x, pend_y;
  logic [14:0] pend_sh, pend_op;

  // shared multiplier
  logic signed [25:0] mul_a, mul_b;
  logic signed [51:0] prod;
  logic               mul_en;

  logic out_free;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  // operand preparation
  logic [24:0] nvx, nvy;
  logic signed [7:0] jd;
  logic [14:0] njit;
  logic [20:0] nsh;

  always_comb begin
    nvx  = (ivx[23] ? (~{ivx[23], ivx} + 25'd1) : {ivx[23], ivx}) + 25'd5;
    nvy  = (ivy[23] ? (~{ivy[23], ivy} + 25'd1) : {ivy[23], ivy}) + 25'd5;
    jd   = $signed({1'b0, ijit}) - 8'sd50;
    njit = {(jd[7] ? (~jd[6:0] + 7'd1) : jd[6:0]), 7'd0} + 15'd2;
    nsh  = {ibr, 14'd0} + 21'd50;
  end

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b0;
    unique case (state)
      ST_SP_VX:  begin mul_a = {1'b0, nvx};        mul_b = RCP_TEN;     mul_en = 1'b1; end
      ST_SP_VY:  begin mul_a = {1'b0, nvy};        mul_b = RCP_TEN;     mul_en = 1'b1; end
      ST_SP_JIT: begin mul_a = {11'd0, njit};      mul_b = RCP_FIVE;    mul_en = 1'b1; end
      ST_SP_SH:  begin mul_a = {5'd0, nsh};        mul_b = RCP_HUNDRED; mul_en = 1'b1; end
      ST_T_MX:   begin mul_a = {{2{rd_vx[23]}}, rd_vx}; mul_b = {10'd0, dt}; mul_en = 1'b1; end
      ST_T_MY:   begin mul_a = {{2{rd_vy[23]}}, rd_vy}; mul_b = {10'd0, dt}; mul_en = 1'b1; end
      default:   begin end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // combinational helpers for spawn and tick
  logic [23:0] q_vel;
  logic [11:0] q_jit;
  logic [14:0] sp_sh;
  logic [23:0] sp_x, sp_y;
  logic [15:0] aged;
  logic [14:0] faded;
  logic        alive;

  always_comb begin
    q_vel = 24'(prod[51:27]);
    q_jit = 12'(prod[27:16]);
    sp_sh = HALF_Q14 + 15'(prod[42:28]);
    sp_x  = ipx + iox + 24'(jit_q);
    sp_y  = ipy + ioy + 24'(jit_q);
    aged  = (rd_live && (rd_life > dlife)) ? (rd_life - dlife) : 16'd0;
    alive = (aged != 16'd0);
    faded = ({1'b0, rd_op} > dalpha) ? (rd_op - 15'(dalpha)) : 15'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      live         <= '0;
      search_start <= '0;
      out_valid    <= 1'b0;
      pend         <= 1'b0;
      idx          <= '0;
      cnt          <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            ipx <= obj_pos_x; ipy <= obj_pos_y;
            ivx <= obj_vel_x; ivy <= obj_vel_y;
            iox <= offset_x;  ioy <= offset_y;
            ijit <= jitter_raw; ibr <= bright_raw;
            dt     <= tick_time;
            dlife  <= 16'(({2'd0, tick_time} * 18'd3) >> 2);
            dalpha <= 16'(({3'd0, tick_time} * 19'd5) >> 3);
            cnt    <= '0;
            pend   <= 1'b0;
            if (action == ACT_SPAWN) begin
              idx   <= search_start;
              state <= ST_SEARCH;
            end else begin
              idx   <= '0;
              state <= ST_T_RD;
            end
          end
        end
        ST_SEARCH: begin
          // walk the live flags, wrapping once
          if (!live[idx]) begin
            state <= ST_SP_VX;
          end else if (cnt == LAST_CNT) begin
            idx   <= '0;
            state <= ST_SP_VX;
          end else begin
            idx <= (idx == LAST_IDX) ? '0 : idx + 1'b1;
            cnt <= cnt + 1'b1;
          end
        end
        ST_SP_VX: state <= ST_SP_VY;
        ST_SP_VY: begin
          vx_q  <= ivx[23] ? -q_vel : q_vel;
          state <= ST_SP_JIT;
        end
        ST_SP_JIT: begin
          vy_q  <= ivy[23] ? -q_vel : q_vel;
          state <= ST_SP_SH;
        end
        ST_SP_SH: begin
          jit_q <= jd[7] ? -q_jit : q_jit;
          state <= ST_SP_WR;
        end
        ST_SP_WR: begin
          if (out_free) begin
            posx_mem[idx]  <= sp_x;
            posy_mem[idx]  <= sp_y;
            velx_mem[idx]  <= vx_q;
            vely_mem[idx]  <= vy_q;
            shade_mem[idx] <= sp_sh;
            op_mem[idx]    <= ONE_Q14[14:0];
            life_mem[idx]  <= ONE_Q14;
            live[idx]      <= 1'b1;
            search_start   <= idx;
            out_valid <= 1'b1;
            kind      <= KIND_SPAWN;
            slot      <= 6'(idx);
            part_x    <= sp_x;
            part_y    <= sp_y;
            shade     <= sp_sh;
            opacity   <= ONE_Q14[14:0];
            last      <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        ST_T_RD: begin
          rd_life <= life_mem[idx];
          rd_live <= live[idx];
          rd_px   <= posx_mem[idx];
          rd_py   <= posy_mem[idx];
          rd_vx   <= velx_mem[idx];
          rd_vy   <= vely_mem[idx];
          rd_sh   <= shade_mem[idx];
          rd_op   <= op_mem[idx];
          state   <= ST_T_MX;
        end
        ST_T_MX: begin
          // age the slot; drop it if life runs out
          if (alive) begin
            life_mem[idx] <= aged;
            state <= ST_T_MY;
          end else begin
            live[idx] <= 1'b0;
            if (idx == LAST_IDX) begin
              state <= ST_T_END;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_T_RD;
            end
          end
        end
        ST_T_MY: begin
          nx    <= rd_px - prod[39:16];
          state <= ST_T_WR;
        end
        ST_T_WR: begin
          if (!pend || out_free) begin
            posx_mem[idx] <= nx;
            posy_mem[idx] <= rd_py - prod[39:16];
            op_mem[idx]   <= faded;
            if (pend) begin
              out_valid <= 1'b1;
              kind      <= KIND_LIVE;
              slot      <= 6'(pend_slot);
              part_x    <= pend_x;
              part_y    <= pend_y;
              shade     <= pend_sh;
              opacity   <= pend_op;
              last      <= 1'b0;
            end
            pend      <= 1'b1;
            pend_slot <= idx;
            pend_x    <= nx;
            pend_y    <= rd_py - prod[39:16];
            pend_sh   <= rd_sh;
            pend_op   <= faded;
            if (idx == LAST_IDX) begin
              state <= ST_T_END;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_T_RD;
            end
          end
        end
        ST_T_END: begin
          if (out_free) begin
            out_valid <= 1'b1;
            last      <= 1'b1;
            if (pend) begin
              kind    <= KIND_LIVE;
              slot    <= 6'(pend_slot);
              part_x  <= pend_x;
              part_y  <= pend_y;
              shade   <= pend_sh;
              opacity <= pend_op;
            end else begin
              kind    <= KIND_NONE;
              slot    <= '0;
              part_x  <= '0;
              part_y  <= '0;
              shade   <= '0;
              opacity <= '0;
            end
            pend  <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: tb/sv/particle_pool_engine_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_pool_engine_unit_tb
// Self-checking bench for the particle pool engine.
// ----------------------------------------------------------------------------
// A queue of spawn and tick beats is filled up front. A clocked driver sends
// them in bursts with random gaps, and a clocked monitor stalls the output on
// a pattern of its own. Every accepted input beat runs through a fixed-point
// model of the pool that pushes the particles it expects onto a queue. Each
// output beat is compared field by field against the oldest entry.
// ----------------------------------------------------------------------------
module particle_pool_engine_unit_tb;
  import ppe_pkg::*;

  localparam int POOL = 32;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 4 * POOL + 40;

  typedef struct packed {
    logic        act;
    logic [15:0] dt;
    logic [23:0] px, py, vx, vy, ox, oy;
    logic [6:0]  jit, bri;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  slot;
    logic [23:0] x, y;
    logic [14:0] sh, op;
    logic        last;
  } particle_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic action = 1'b0;
  logic [15:0] tick_time = '0;
  logic signed [23:0] obj_pos_x = '0, obj_pos_y = '0, obj_vel_x = '0, obj_vel_y = '0;
  logic signed [23:0] offset_x = '0, offset_y = '0;
  logic [6:0] jitter_raw = '0, bright_raw = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] kind;
  logic [5:0] slot;
  logic signed [23:0] part_x, part_y;
  logic [14:0] shade, opacity;
  logic last;

  particle_pool_engine_unit #(.POOL_SIZE(POOL)) dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Model of the pool state.
  logic [15:0] m_life [POOL];
  logic [23:0] m_px [POOL], m_py [POOL], m_vx [POOL], m_vy [POOL];
  logic [14:0] m_sh [POOL], m_op [POOL];
  int unsigned m_start;

  cmd_t      pending_cmds [$];
  particle_t expected_parts [$];
  int        errors = 0;

  // Append to the tail of the stimulus and expectation queues.
  task automatic add_cmd(cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  task automatic add_part(particle_t p);
    expected_parts.insert(expected_parts.size(), p);
  endtask

  // Nearest, ties away from zero.
  function automatic longint rdiv(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint sx(logic [23:0] v);
    return longint'(signed'(v));
  endfunction

  // Update the pool model with one accepted beat and queue its particles.
  task automatic predict_pool(cmd_t c);
    int unsigned s, dl, da, n;
    longint j, dx, dy;
    bit found;
    particle_t p;
    if (c.act == ACT_SPAWN) begin
      found = 1'b0;
      s = 0;
      for (int i = 0; i < POOL; i++) begin
        if (!found && i >= m_start && m_life[i] == 0) begin
          s = i; found = 1'b1;
        end
      end
      for (int i = 0; i < POOL; i++) begin
        if (!found && i < m_start && m_life[i] == 0) begin
          s = i; found = 1'b1;
        end
      end
      m_start = s;
      j = rdiv((longint'(c.jit) - 50) * 128, 5);
      m_px[s] = 24'(sx(c.px) + sx(c.ox) + j);
      m_py[s] = 24'(sx(c.py) + sx(c.oy) + j);
      m_vx[s] = 24'(rdiv(sx(c.vx), 10));
      m_vy[s] = 24'(rdiv(sx(c.vy), 10));
      m_sh[s] = 15'(8192 + (int'(c.bri) * 16384 + 50) / 100);
      m_op[s] = 15'(ONE_Q14);
      m_life[s] = ONE_Q14;
      p = '{KIND_SPAWN, 6'(s), m_px[s], m_py[s], m_sh[s], m_op[s], 1'b1};
      add_part(p);
    end else begin
      dl = (3 * c.dt) >> 2;
      da = (5 * c.dt) >> 3;
      n = 0;
      for (int i = 0; i < POOL; i++) begin
        m_life[i] = (m_life[i] > dl) ? 16'(m_life[i] - dl) : 16'd0;
        if (m_life[i] != 0) begin
          dx = sx(m_vx[i]) * longint'(c.dt) >>> 16;
          dy = sx(m_vy[i]) * longint'(c.dt) >>> 16;
          m_px[i] = 24'(sx(m_px[i]) - dx);
          m_py[i] = 24'(sx(m_py[i]) - dy);
          m_op[i] = (m_op[i] > da) ? 15'(m_op[i] - da) : 15'd0;
          p = '{KIND_LIVE, 6'(i), m_px[i], m_py[i], m_sh[i], m_op[i], 1'b0};
          add_part(p);
          n++;
        end
      end
      if (n == 0) begin
        p = '{KIND_NONE, 6'd0, 24'd0, 24'd0, 15'd0, 15'd0, 1'b1};
        add_part(p);
      end else expected_parts[$].last = 1'b1;
    end
  endtask

  function automatic logic [23:0] rnd24();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'(int'($urandom_range(0, 8000)) - 4000);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic cmd_t make_cmd(logic act, logic [15:0] dt);
    cmd_t c;
    c.act = act;
    c.dt = dt;
    c.px = rnd24(); c.py = rnd24(); c.vx = rnd24(); c.vy = rnd24();
    c.ox = rnd24(); c.oy = rnd24();
    c.jit = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 99));
    c.bri = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 99));
    return c;
  endfunction

  // Driver: bursts of beats with random gaps between them.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_pool(pending_cmds.pop_front());
      end
      if (in_valid && !in_ready) begin
        // hold the beat until accepted
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_cmds.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        action <= pending_cmds[0].act;
        tick_time <= pending_cmds[0].dt;
        obj_pos_x <= pending_cmds[0].px;
        obj_pos_y <= pending_cmds[0].py;
        obj_vel_x <= pending_cmds[0].vx;
        obj_vel_y <= pending_cmds[0].vy;
        offset_x <= pending_cmds[0].ox;
        offset_y <= pending_cmds[0].oy;
        jitter_raw <= pending_cmds[0].jit;
        bright_raw <= pending_cmds[0].bri;
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 6);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // Monitor: check each output beat, stall on a rotating pattern.
  int unsigned stall_phase = 0;
  always @(posedge clk) begin
    particle_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_parts.size() == 0) begin
          $error("unexpected output beat kind=%0d slot=%0d", kind, slot);
          errors++;
        end else begin
          e = expected_parts.pop_front();
          if (kind !== e.kind) begin
            $error("kind: expected %0d actual %0d", e.kind, kind); errors++;
          end
          if (slot !== e.slot) begin
            $error("slot: expected %0d actual %0d", e.slot, slot); errors++;
          end
          if (part_x !== e.x) begin
            $error("part_x: expected %h actual %h", e.x, part_x); errors++;
          end
          if (part_y !== e.y) begin
            $error("part_y: expected %h actual %h", e.y, part_y); errors++;
          end
          if (shade !== e.sh) begin
            $error("shade: expected %0d actual %0d", e.sh, shade); errors++;
          end
          if (opacity !== e.op) begin
            $error("opacity: expected %0d actual %0d", e.op, opacity); errors++;
          end
          if (last !== e.last) begin
            $error("last: expected %0d actual %0d", e.last, last); errors++;
          end
        end
      end
      // stretches of free flow alternate with heavy stalls
      stall_phase <= stall_phase + 1;
      if (stall_phase[9:8] == 2'd0) out_ready <= 1'b1;
      else if (stall_phase[9:8] == 2'd1) out_ready <= ($urandom_range(0, 3) == 0);
      else out_ready <= ($urandom_range(0, 1) == 0);
    end
  end

  // Watchdog: cycles with no accepted beat on either side.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    cmd_t c;
    for (int i = 0; i < POOL; i++) m_life[i] = '0;
    m_start = 0;
    // Directed: empty tick, field extremes, a run of spawns, saturating ticks.
    add_cmd(make_cmd(ACT_TICK, 16'hFFFF));
    c = make_cmd(ACT_SPAWN, 16'd0);
    c.px = 24'h7FFFFF; c.ox = 24'h7FFFFF; c.vx = 24'h7FFFFF; c.vy = 24'h800000;
    c.py = 24'h800000; c.oy = 24'h800000; c.jit = 7'd0; c.bri = 7'd0;
    add_cmd(c);
    c = make_cmd(ACT_SPAWN, 16'd0);
    c.jit = 7'd127; c.bri = 7'd127; c.vx = 24'd5; c.vy = 24'hFFFFFB;
    add_cmd(c);
    c = make_cmd(ACT_SPAWN, 16'd0);
    c.jit = 7'd99; c.bri = 7'd99;
    add_cmd(c);
    add_cmd(make_cmd(ACT_TICK, 16'd0));
    add_cmd(make_cmd(ACT_TICK, 16'd100));
    for (int i = 0; i < 14; i++) add_cmd(make_cmd(ACT_SPAWN, 16'd0));
    add_cmd(make_cmd(ACT_TICK, 16'd1));
    add_cmd(make_cmd(ACT_TICK, 16'd21845));
    add_cmd(make_cmd(ACT_TICK, 16'hFFFF));
    // Random: spawns dominate so the pool fills and wraps, ticks age it.
    for (int i = 0; i < 137; i++) begin
      if ($urandom_range(0, 3) == 0)
        add_cmd(make_cmd(ACT_TICK,
          ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000))));
      else
        add_cmd(make_cmd(ACT_SPAWN, 16'($urandom)));
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (pending_cmds.size() == 0 && !in_valid);
    wait (expected_parts.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_parts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: particle_pool_engine_unit.f
hw/rtl/ppe_pkg.sv
hw/rtl/particle_pool_engine_unit.sv
tb/sv/particle_pool_engine_unit_tb.sv
